// ===== hdl/bic_pkg.sv =====
package bic_pkg;

  // operation codes carried by an input item
  localparam logic [1:0] OP_UPDATE = 2'd0;
  localparam logic [1:0] OP_WRITE  = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;
  localparam logic [1:0] OP_NOP    = 2'd3;

  // register map, byte offsets
  localparam logic [5:0] OFS_PEND_BASIC    = 6'h00;
  localparam logic [5:0] OFS_PEND1         = 6'h04;
  localparam logic [5:0] OFS_PEND2         = 6'h08;
  localparam logic [5:0] OFS_FIQCTL        = 6'h0c;
  localparam logic [5:0] OFS_ENABLE1       = 6'h10;
  localparam logic [5:0] OFS_ENABLE2       = 6'h14;
  localparam logic [5:0] OFS_ENABLE_BASIC  = 6'h18;
  localparam logic [5:0] OFS_DISABLE1      = 6'h1c;
  localparam logic [5:0] OFS_DISABLE2      = 6'h20;
  localparam logic [5:0] OFS_DISABLE_BASIC = 6'h24;

  localparam int unsigned BANK_W  = 32;
  localparam int unsigned BASIC_W = 8;
  localparam int unsigned NUM_W   = 7;
  localparam int unsigned STAT_W  = 10;

  localparam logic [NUM_W-1:0] IRQ_COUNT_RESET = 7'd72;
  localparam logic [NUM_W-1:0] BANK2_BASE      = 7'd32;
  localparam logic [NUM_W-1:0] BASIC_BASE      = 7'd64;

  // pending vectors after an item has been applied
  typedef struct packed {
    logic [BANK_W-1:0]  bank1;
    logic [BANK_W-1:0]  bank2;
    logic [BASIC_W-1:0] basic;
  } pend_t;

  // dispatch choice
  typedef struct packed {
    logic             pending;
    logic             valid;
    logic [NUM_W-1:0] number;
  } sel_t;

endpackage

// ===== hdl/bic_ifs.sv =====
interface bic_in_if import bic_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic [5:0]         reg_offset;
  logic [BANK_W-1:0]  write_data;
  logic [BANK_W-1:0]  lines_bank1;
  logic [BANK_W-1:0]  lines_bank2;
  logic [BASIC_W-1:0] lines_basic;

  modport source (output valid, opcode, reg_offset, write_data, lines_bank1, lines_bank2,
                  lines_basic, input ready);
  modport sink   (input valid, opcode, reg_offset, write_data, lines_bank1, lines_bank2,
                  lines_basic, output ready);
endinterface

interface bic_out_if import bic_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BANK_W-1:0] read_data;
  logic              irq_pending;
  logic              irq_valid;
  logic [NUM_W-1:0]  irq_number;

  modport source (output valid, read_data, irq_pending, irq_valid, irq_number, input ready);
  modport sink   (input valid, read_data, irq_pending, irq_valid, irq_number, output ready);
endinterface

// ===== hdl/bic_regfile.sv =====
module bic_regfile import bic_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               commit_i,
  input  logic [1:0]         opcode_i,
  input  logic [5:0]         reg_offset_i,
  input  logic [BANK_W-1:0]  write_data_i,
  input  logic [BANK_W-1:0]  lines_bank1_i,
  input  logic [BANK_W-1:0]  lines_bank2_i,
  input  logic [BASIC_W-1:0] lines_basic_i,
  output logic [BANK_W-1:0]  read_data_o,
  output pend_t              pend_o
);

  logic [BANK_W-1:0]  en1_q, en1_d, en2_q, en2_d;
  logic [BASIC_W-1:0] enb_q, enb_d;
  logic [BANK_W-1:0]  src1_q, src1_d, src2_q, src2_d;
  logic [BASIC_W-1:0] srcb_q, srcb_d;
  logic [BANK_W-1:0]  p1_cur, p2_cur;
  logic [BASIC_W-1:0] pb_cur;
  logic [STAT_W-1:0]  status_cur;

  // next state: line update or masked enable set/clear
  always_comb begin
    en1_d  = en1_q;
    en2_d  = en2_q;
    enb_d  = enb_q;
    src1_d = src1_q;
    src2_d = src2_q;
    srcb_d = srcb_q;
    case (opcode_i)
      OP_UPDATE: begin
        src1_d = lines_bank1_i;
        src2_d = lines_bank2_i;
        srcb_d = lines_basic_i;
      end
      OP_WRITE: begin
        case (reg_offset_i)
          OFS_ENABLE1:       en1_d = en1_q | write_data_i;
          OFS_ENABLE2:       en2_d = en2_q | write_data_i;
          OFS_ENABLE_BASIC:  enb_d = enb_q | write_data_i[BASIC_W-1:0];
          OFS_DISABLE1:      en1_d = en1_q & ~write_data_i;
          OFS_DISABLE2:      en2_d = en2_q & ~write_data_i;
          OFS_DISABLE_BASIC: enb_d = enb_q & ~write_data_i[BASIC_W-1:0];
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en1_q  <= '0;
      en2_q  <= '0;
      enb_q  <= '0;
      src1_q <= '0;
      src2_q <= '0;
      srcb_q <= '0;
    end else if (commit_i) begin
      en1_q  <= en1_d;
      en2_q  <= en2_d;
      enb_q  <= enb_d;
      src1_q <= src1_d;
      src2_q <= src2_d;
      srcb_q <= srcb_d;
    end
  end

  // read path, reads leave the state untouched
  assign p1_cur     = src1_q & en1_q;
  assign p2_cur     = src2_q & en2_q;
  assign pb_cur     = srcb_q & enb_q;
  assign status_cur = {|p2_cur, |p1_cur, pb_cur};

  always_comb begin
    read_data_o = '0;
    if (opcode_i == OP_READ) begin
      case (reg_offset_i)
        OFS_PEND_BASIC:                  read_data_o = {{(BANK_W-STAT_W){1'b0}}, status_cur};
        OFS_PEND1:                       read_data_o = p1_cur;
        OFS_PEND2:                       read_data_o = p2_cur;
        OFS_ENABLE1, OFS_DISABLE1:       read_data_o = en1_q;
        OFS_ENABLE2, OFS_DISABLE2:       read_data_o = en2_q;
        OFS_ENABLE_BASIC, OFS_DISABLE_BASIC:
                                         read_data_o = {{(BANK_W-BASIC_W){1'b0}}, enb_q};
        default:                         read_data_o = '0;
      endcase
    end
  end

  // pending after this item
  assign pend_o.bank1 = src1_d & en1_d;
  assign pend_o.bank2 = src2_d & en2_d;
  assign pend_o.basic = srcb_d & enb_d;

endmodule

// ===== hdl/bic_prio.sv =====
module bic_prio import bic_pkg::*; (
  input  pend_t            pend_i,
  input  logic [NUM_W-1:0] irq_count_i,
  output sel_t             sel_o
);

  function automatic logic [4:0] lowest_set(input logic [BANK_W-1:0] v);
    logic [4:0] n;
    n = '0;
    for (int i = BANK_W - 1; i >= 0; i--) begin
      if (v[i]) n = 5'(i);
    end
    return n;
  endfunction

  logic             any1, any2, anyb;
  logic [4:0]       idx1, idx2, idxb;
  logic [NUM_W-1:0] num_raw;
  logic             found;

  assign any1 = |pend_i.bank1;
  assign any2 = |pend_i.bank2;
  assign anyb = |pend_i.basic;
  assign idx1 = lowest_set(pend_i.bank1);
  assign idx2 = lowest_set(pend_i.bank2);
  assign idxb = lowest_set({{(BANK_W-BASIC_W){1'b0}}, pend_i.basic});

  // bank 1 first, then bank 2, then basic
  always_comb begin
    found   = 1'b1;
    num_raw = '0;
    if (any1)      num_raw = {2'b00, idx1};
    else if (any2) num_raw = BANK2_BASE | {2'b00, idx2};
    else if (anyb) num_raw = BASIC_BASE | {2'b00, idxb};
    else           found   = 1'b0;
  end

  assign sel_o.pending = any1 | any2 | anyb;
  assign sel_o.valid   = found && (num_raw < irq_count_i);
  assign sel_o.number  = sel_o.valid ? num_raw : '0;

endmodule

// ===== hdl/banked_interrupt_controller.sv =====
// channel | dir | handshake      | payload
// in_i    | in  | valid / ready  | opcode, reg_offset, write_data, lines_bank1/2, lines_basic
// out_o   | out | valid / ready  | read_data, irq_pending, irq_valid, irq_number
// cfg     | in  | cfg_we_i       | cfg_wdata_i = irq_count
//
// one item per cycle sustained while the output is not held off; the result register
// loads from the input register when that item advances, and the result is then offered
// (input register, then state update and priority encode into the result register)
// reset clears enables, source lines and valids, and sets irq_count to 72
// a stalled output holds its result; the input register keeps filling while the
// result register drains, so the input side stalls only when both are full and the
// output is held off
module banked_interrupt_controller import bic_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [NUM_W-1:0] cfg_wdata_i,
  bic_in_if.sink           in_i,
  bic_out_if.source        out_o
);

  logic               in_valid_q;
  logic [1:0]         opcode_q;
  logic [5:0]         reg_offset_q;
  logic [BANK_W-1:0]  write_data_q;
  logic [BANK_W-1:0]  lines_bank1_q;
  logic [BANK_W-1:0]  lines_bank2_q;
  logic [BASIC_W-1:0] lines_basic_q;

  logic               out_valid_q;
  logic [BANK_W-1:0]  read_data_q;
  sel_t               sel_q;

  logic [NUM_W-1:0]   irq_count_q;

  logic               adv_out, adv_in, in_acc;
  logic [BANK_W-1:0]  read_data;
  pend_t              pend;
  sel_t               sel;

  // flow control
  assign adv_out    = !out_valid_q || out_o.ready;
  assign adv_in     = in_valid_q && adv_out;
  assign in_i.ready = !in_valid_q || adv_out;
  assign in_acc     = in_i.valid && in_i.ready;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      irq_count_q <= IRQ_COUNT_RESET;
    end else if (cfg_we_i) begin
      irq_count_q <= cfg_wdata_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_acc) begin
      in_valid_q <= 1'b1;
    end else if (adv_in) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      opcode_q      <= in_i.opcode;
      reg_offset_q  <= in_i.reg_offset;
      write_data_q  <= in_i.write_data;
      lines_bank1_q <= in_i.lines_bank1;
      lines_bank2_q <= in_i.lines_bank2;
      lines_basic_q <= in_i.lines_basic;
    end
  end

  bic_regfile u_regfile (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .commit_i      (adv_in),
    .opcode_i      (opcode_q),
    .reg_offset_i  (reg_offset_q),
    .write_data_i  (write_data_q),
    .lines_bank1_i (lines_bank1_q),
    .lines_bank2_i (lines_bank2_q),
    .lines_basic_i (lines_basic_q),
    .read_data_o   (read_data),
    .pend_o        (pend)
  );

  bic_prio u_prio (
    .pend_i      (pend),
    .irq_count_i (irq_count_q),
    .sel_o       (sel)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv_out) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_in) begin
      read_data_q <= read_data;
      sel_q       <= sel;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.read_data   = read_data_q;
  assign out_o.irq_pending = sel_q.pending;
  assign out_o.irq_valid   = sel_q.valid;
  assign out_o.irq_number  = sel_q.number;

endmodule

// ===== hdl/bic_checker.sv =====
module bic_checker import bic_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid,
  input logic              out_ready,
  input logic [BANK_W-1:0] read_data,
  input logic              irq_pending,
  input logic              irq_valid,
  input logic [NUM_W-1:0]  irq_number
);

  // a dispatched number needs something pending
  a_valid_needs_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && irq_valid |-> irq_pending)
    else $error("irq_valid without irq_pending");

  // no choice reports number zero
  a_number_zero_when_invalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !irq_valid |-> irq_number == '0)
    else $error("irq_number not zero without a choice");

  // numbers stay inside the 72 sources
  a_number_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> irq_number < IRQ_COUNT_RESET)
    else $error("irq_number out of range");

  // a stalled result holds
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(read_data) && $stable(irq_pending)
      && $stable(irq_valid) && $stable(irq_number))
    else $error("stalled result changed");

endmodule

bind banked_interrupt_controller bic_checker u_bic_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid   (out_o.valid),
  .out_ready   (out_o.ready),
  .read_data   (out_o.read_data),
  .irq_pending (out_o.irq_pending),
  .irq_valid   (out_o.irq_valid),
  .irq_number  (out_o.irq_number)
);
